### rtl/core/mtg_pkg.sv
package mtg_pkg;

  // Default geometry of the generator
  localparam int STATE_DEPTH_DEF  = 624;
  localparam int TWIST_OFFSET_DEF = 397;

  // Fixed field widths
  localparam int WORD_W       = 32;
  localparam int CMD_W        = 2;
  localparam int LOAD_INDEX_W = 10;
  localparam int S_TDATA_W    = 48;   // load_index + load_word, padded to bytes

  // Request kinds (travel on s_tuser)
  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESEED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

  // Algorithm constants
  localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] LCG_MUL   = 32'd69069;
  localparam logic [WORD_W-1:0] AUTO_SEED = 32'd4357;

  // Controller to datapath commands
  typedef struct packed {
    logic seed_init;   // load LCG state and clear step counter
    logic seed_auto;   // with seed_init: use the built-in seed
    logic seed_hi;     // first LCG step of a word
    logic seed_lo;     // second LCG step, write the word
    logic tw_prime;    // read word 0 ahead of the twist
    logic tw_read;     // twist read phase
    logic tw_write;    // twist write phase
    logic emit;        // temper read data into output register
    logic load;        // write one word from the request
  } dp_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic step_last;   // step counter on the final table entry
    logic pos_full;    // every word used, twist due
    logic unseeded;    // table never seeded
    logic out_free;    // output register can take a word
  } dp_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### rtl/core/mtg_ctrl.sv
module mtg_ctrl
  import mtg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SEED_HI   = 3'd1;
  localparam logic [2:0] S_SEED_LO   = 3'd2;
  localparam logic [2:0] S_TW_PRIME  = 3'd3;
  localparam logic [2:0] S_TW_READ   = 3'd4;
  localparam logic [2:0] S_TW_WRITE  = 3'd5;
  localparam logic [2:0] S_DRAW_READ = 3'd6;
  localparam logic [2:0] S_DRAW_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       draw_pend;       // a draw waits behind the auto-seed
  logic       draw_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      draw_pend <= 1'b0;
    end else begin
      state     <= state_next;
      draw_pend <= draw_pend_next;
    end
  end

  always_comb begin
    state_next     = state;
    draw_pend_next = draw_pend;
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_DRAW: begin
              if (status.unseeded) begin
                cmd.seed_init  = 1'b1;
                cmd.seed_auto  = 1'b1;
                draw_pend_next = 1'b1;
                state_next     = S_SEED_HI;
              end else if (status.pos_full) begin
                state_next = S_TW_PRIME;
              end else begin
                state_next = S_DRAW_EMIT;
              end
            end
            CMD_RESEED: begin
              cmd.seed_init  = 1'b1;
              draw_pend_next = 1'b0;
              state_next     = S_SEED_HI;
            end
            CMD_LOAD: begin
              cmd.load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SEED_HI: begin
        cmd.seed_hi = 1'b1;
        state_next  = S_SEED_LO;
      end
      S_SEED_LO: begin
        cmd.seed_lo = 1'b1;
        if (status.step_last) begin
          draw_pend_next = 1'b0;
          state_next     = draw_pend ? S_TW_PRIME : S_IDLE;
        end else begin
          state_next = S_SEED_HI;
        end
      end
      S_TW_PRIME: begin
        cmd.tw_prime = 1'b1;
        state_next   = S_TW_READ;
      end
      S_TW_READ: begin
        cmd.tw_read = 1'b1;
        state_next  = S_TW_WRITE;
      end
      S_TW_WRITE: begin
        cmd.tw_write = 1'b1;
        state_next   = status.step_last ? S_DRAW_READ : S_TW_READ;
      end
      S_DRAW_READ: begin
        state_next = S_DRAW_EMIT;
      end
      S_DRAW_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/mtg_datapath.sv
module mtg_datapath
  import mtg_pkg::*;
#(
  parameter int STATE_DEPTH  = STATE_DEPTH_DEF,
  parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic                    cfg_we,
  input  logic [WORD_W-1:0]       cfg_wdata,
  input  logic [LOAD_INDEX_W-1:0] load_index,
  input  logic [WORD_W-1:0]       load_word,
  input  logic                    load_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WORD_W-1:0]       out_data
);

  localparam int ADDR_W = $clog2(STATE_DEPTH);
  localparam int POS_W  = $clog2(STATE_DEPTH + 2);
  localparam logic [POS_W-1:0]  POS_FULL     = POS_W'(STATE_DEPTH);
  localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_DEPTH + 1);
  localparam logic [ADDR_W-1:0] STEP_LAST    = ADDR_W'(STATE_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_EXT    = (ADDR_W+1)'(STATE_DEPTH);
  localparam logic [ADDR_W:0]   OFFSET_EXT   = (ADDR_W+1)'(TWIST_OFFSET);

  logic [WORD_W-1:0] mem [STATE_DEPTH];
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [WORD_W-1:0] seed_cfg;
  logic [WORD_W-1:0] seed_state;
  logic [WORD_W-1:0] lcg_next;
  logic [15:0]       word_hi;
  logic [ADDR_W-1:0] step;
  logic [ADDR_W-1:0] step_nxt;
  logic [ADDR_W:0]   far_sum;
  logic [ADDR_W-1:0] step_far;
  logic              carry;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] twisted;
  logic [POS_W-1:0]  pos;
  logic              load_in_range;

  // State table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  assign lcg_next = seed_state * LCG_MUL + 32'd1;

  assign step_nxt = (step == STEP_LAST) ? '0 : step + 1'b1;
  assign far_sum  = {1'b0, step} + OFFSET_EXT;
  assign step_far = (far_sum >= DEPTH_EXT) ? ADDR_W'(far_sum - DEPTH_EXT)
                                           : far_sum[ADDR_W-1:0];

  assign twist_y = {carry, rd_a[WORD_W-2:0]};
  assign twisted = rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

  assign load_in_range = 32'(load_index) < 32'(STATE_DEPTH);

  always_comb begin
    if (cmd.tw_prime) begin
      addr_a = '0;
    end else if (cmd.tw_read || cmd.tw_write) begin
      addr_a = step_nxt;
    end else begin
      addr_a = pos[ADDR_W-1:0];
    end
    addr_b = step_far;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = step;
    wr_data = twisted;
    priority if (cmd.seed_lo) begin
      wr_en   = 1'b1;
      wr_data = {word_hi, seed_state[WORD_W-1:16]};
    end else if (cmd.tw_write) begin
      wr_en = 1'b1;
    end else if (cmd.load && load_in_range) begin
      wr_en   = 1'b1;
      wr_addr = load_index[ADDR_W-1:0];
      wr_data = load_word;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_cfg  <= AUTO_SEED;
      pos       <= POS_UNSEEDED;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_cfg <= cfg_wdata;
      end
      priority if (cmd.seed_lo && step == STEP_LAST) begin
        pos <= POS_FULL;
      end else if (cmd.tw_write && step == STEP_LAST) begin
        pos <= '0;
      end else if (cmd.emit) begin
        pos <= pos + 1'b1;
      end else if (cmd.load && load_last) begin
        pos <= POS_FULL;
      end else begin
        pos <= pos;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      seed_state <= cmd.seed_auto ? AUTO_SEED : seed_cfg;
    end else if (cmd.seed_hi || cmd.seed_lo) begin
      seed_state <= lcg_next;
    end
    if (cmd.seed_hi) begin
      word_hi <= seed_state[WORD_W-1:16];
    end
    if (cmd.seed_init || cmd.tw_prime) begin
      step <= '0;
    end else if (cmd.seed_lo || cmd.tw_write) begin
      step <= step + 1'b1;
    end
    if (cmd.tw_read) begin
      carry <= rd_a[WORD_W-1];
    end
    if (cmd.emit) begin
      out_data <= temper(rd_a);
    end
  end

  assign status.step_last = (step == STEP_LAST);
  assign status.pos_full  = (pos == POS_FULL);
  assign status.unseeded  = (pos == POS_UNSEEDED);
  assign status.out_free  = !out_valid || out_ready;

endmodule

### rtl/core/mersenne_twister_generator_top.sv
// MT19937 generator with the original 1998 seeding. Requests arrive on the
// s_ stream, the kind in s_tuser: draw returns one tempered 32-bit word on
// the m_ stream; reseed refills the 624-word table from the seed register
// (cfg_we/cfg_wdata, reset 4357) with the 69069 LCG; load writes one table
// word and, with s_tlast set, marks the table full so the next draw twists.
// A draw on a never-seeded table seeds it from 4357 first. A plain draw
// reads the table, then tempers the word into the output register; a draw
// that finds the table used up first runs the twist, one entry at a time,
// a read phase then a write phase; a reseed makes two LCG multiplies per
// word through one shared multiplier; a load is done in the idle state.
// A finished word may sit in the output register while the next request
// is taken. Only one request is worked at a time.
module mersenne_twister_generator_top
  import mtg_pkg::*;
#(
  parameter int STATE_DEPTH  = STATE_DEPTH_DEF,
  parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] load_index, [41:10] load_word
  input  logic [CMD_W-1:0]     s_tuser,   // [1:0] command
  input  logic                 s_tlast,   // load_last
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WORD_W-1:0]    m_tdata,   // [31:0] random_word
  // seed register
  input  logic                 cfg_we,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: sequences seed, twist and draw phases
  mtg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: state table, LCG, twist and temper, output register
  mtg_datapath #(
    .STATE_DEPTH  (STATE_DEPTH),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .load_index (s_tdata[LOAD_INDEX_W-1:0]),
    .load_word  (s_tdata[LOAD_INDEX_W +: WORD_W]),
    .load_last  (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

### rtl/core/mtg_checker.sv
module mtg_checker
  import mtg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [CMD_W-1:0]  s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [WORD_W-1:0] m_tdata
);

  logic s_take;
  assign s_take = s_tvalid && s_tready;

  // Output register empties on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Draw and reseed always leave the controller busy once taken
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    s_take && (s_tuser == CMD_DRAW || s_tuser == CMD_RESEED) |=> !s_tready)
    else $error("ready straight after draw or reseed");

  // A load finishes in its own cycle
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    s_take && s_tuser == CMD_LOAD |=> s_tready)
    else $error("not ready after load");

  // A new word appears only as the controller returns to idle
  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result raised while busy");

endmodule

bind mersenne_twister_generator_top mtg_checker u_chk (.*);

### test/mersenne_twister_generator_top_tb.sv
module mersenne_twister_generator_top_tb;
  import mtg_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int TBL_DEPTH     = STATE_DEPTH_DEF;
  localparam int TBL_OFFSET    = TWIST_OFFSET_DEF;
  localparam int MAX_GAP       = 16;
  localparam int SETTLE_CYCLES = 1400;          // longer than a reseed
  localparam int RANDOM_ITEMS  = 1600;
  localparam int PHASES        = 6;
  localparam int RUN_LIMIT     = 200_000_000;
  localparam int DIRECTED_N    = 23;
  localparam int INDEX_MAX     = (1 << LOAD_INDEX_W) - 1;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] MSB_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LSBS_MASK  = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] HALF_MASK  = 32'hffff_0000;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [LOAD_INDEX_W-1:0] idx;
    logic [WORD_W-1:0]       word;
    logic                    last;
    logic                    pinned;       // expected word given by hand
    logic [WORD_W-1:0]       pinned_word;
  } request_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]     s_tuser = CMD_DRAW;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_W-1:0]    m_tdata;
  logic                 cfg_we = 1'b0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // generator copy kept by the bench
  logic [WORD_W-1:0] gen_tbl [TBL_DEPTH];
  int unsigned       gen_pos;
  logic [WORD_W-1:0] gen_seed;
  bit                tbl_filled;   // every table word written at least once

  logic [WORD_W-1:0] expected_words [$];
  int                mismatch_cnt = 0;
  bit                calm = 1'b0;  // no idling on either side while set

  // Directed requests: extremes, every command, the corner cases
  request_t directed_reqs [0:DIRECTED_N-1] = '{
    '{CMD_LOAD,   10'd5,    32'hffff_ffff, 1'b0, 1'b0, 32'h0}, // lost to the auto-seed
    '{CMD_LOAD,   10'd1023, 32'h0000_0000, 1'b0, 1'b0, 32'h0}, // index out of range
    '{CMD_UNUSED, 10'd1023, 32'hffff_ffff, 1'b1, 1'b0, 32'h0}, // ignored
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0}, // never seeded: 4357, twist
    '{CMD_DRAW,   10'd1023, 32'hffff_ffff, 1'b1, 1'b0, 32'h0},
    '{CMD_LOAD,   10'd2,    32'h0000_0000, 1'b0, 1'b0, 32'h0}, // next word to be read
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b1, 32'h0}, // zero tempers to zero
    '{CMD_RESEED, 10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0}, // seed register at zero
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_LOAD,   10'd623,  32'hffff_ffff, 1'b0, 1'b0, 32'h0}, // top entry
    '{CMD_LOAD,   10'd624,  32'h1234_5678, 1'b1, 1'b0, 32'h0}, // dropped, still marks full
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0}, // twist
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_LOAD,   10'd2,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b1, 32'h0},
    '{CMD_LOAD,   10'd512,  32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_UNUSED, 10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_RESEED, 10'd1023, 32'hffff_ffff, 1'b1, 1'b0, 32'h0},
    '{CMD_LOAD,   10'd1,    32'haaaa_aaaa, 1'b0, 1'b0, 32'h0}, // feeds the next twist
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{CMD_DRAW,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  logic [WORD_W-1:0] phase_seeds [PHASES] = '{
    32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff
  };

  mersenne_twister_generator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic void fill_table(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] w;
    s = seed;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      w = s & HALF_MASK;
      s = s * LCG_MUL + 32'd1;
      w = w | ((s & HALF_MASK) >> 16);
      s = s * LCG_MUL + 32'd1;
      gen_tbl[i] = w;
    end
    gen_pos = TBL_DEPTH;
  endfunction

  function automatic void twist_table();
    logic [WORD_W-1:0] y;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      y = (gen_tbl[k] & MSB_MASK) | (gen_tbl[(k + 1) % TBL_DEPTH] & LSBS_MASK);
      gen_tbl[k] = gen_tbl[(k + TBL_OFFSET) % TBL_DEPTH] ^ (y >> 1) ^
                   (y[0] ? TWIST_XOR : '0);
    end
    gen_pos = 0;
  endfunction

  function automatic logic [WORD_W-1:0] next_word();
    logic [WORD_W-1:0] y;
    if (gen_pos >= TBL_DEPTH) begin
      if (gen_pos != TBL_DEPTH)
        fill_table(AUTO_SEED);
      twist_table();
    end
    y = gen_tbl[gen_pos];
    gen_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  // Advance the bench copy on an accepted request, queue any word due
  function automatic void predict_request(input request_t r);
    logic [WORD_W-1:0] w;
    case (r.cmd)
      CMD_DRAW: begin
        w = next_word();
        expected_words.push_back(r.pinned ? r.pinned_word : w);
        tbl_filled = 1'b1;
      end
      CMD_RESEED: begin
        fill_table(gen_seed);
        tbl_filled = 1'b1;
      end
      CMD_LOAD: begin
        if (r.idx < TBL_DEPTH)
          gen_tbl[r.idx] = r.word;
        if (r.last)
          gen_pos = TBL_DEPTH;
      end
      default: ;
    endcase
  endfunction

  function automatic request_t make_request(input logic [CMD_W-1:0] cmd,
                                            input logic [LOAD_INDEX_W-1:0] idx,
                                            input logic last);
    request_t r;
    r.cmd         = cmd;
    r.idx         = idx;
    r.word        = $urandom();
    r.last        = last;
    r.pinned      = 1'b0;
    r.pinned_word = '0;
    return r;
  endfunction

  // Hold off for a drawn gap, then offer the request until taken
  task automatic send_request(input request_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - WORD_W - LOAD_INDEX_W){1'b0}}, r.word, r.idx};
    s_tuser  <= r.cmd;
    s_tlast  <= r.last;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    predict_request(r);
  endtask

  // Drain results, then cover a reseed that may still be running
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] seed);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_seed = seed;
  endtask

  initial begin : stimulus
    int done;
    int pick;
    int n;
    foreach (gen_tbl[i]) gen_tbl[i] = '0;
    gen_pos    = TBL_DEPTH + 1;
    gen_seed   = AUTO_SEED;
    tbl_filled = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_seed('0);
    for (int i = 0; i < DIRECTED_N; i++)
      send_request(directed_reqs[i]);

    for (int p = 0; p < PHASES; p++) begin
      // sender waits for every word before the seed changes
      settle();
      write_seed((p % 3 == 2) ? $urandom() : phase_seeds[p]);
      done = 0;
      while (done < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 15) == 0)
          calm = !calm;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          send_request(make_request(CMD_DRAW,
                                    LOAD_INDEX_W'($urandom_range(0, INDEX_MAX)),
                                    1'($urandom_range(0, 1))));
          done++;
        end else if (pick < 72) begin
          n = $urandom_range(5, 20);
          repeat (n)
            send_request(make_request(CMD_DRAW,
                                      LOAD_INDEX_W'($urandom_range(0, INDEX_MAX)),
                                      1'($urandom_range(0, 1))));
          done += n;
        end else if (pick < 80) begin
          // burst of loads, the last one marks full once the table is whole
          n = $urandom_range(1, 5);
          for (int j = 0; j < n; j++)
            send_request(make_request(CMD_LOAD,
                                      LOAD_INDEX_W'($urandom_range(0, TBL_DEPTH - 1)),
                                      (j == n - 1) && tbl_filled));
          done += n;
        end else if (pick < 84) begin
          send_request(make_request(CMD_RESEED,
                                    LOAD_INDEX_W'($urandom_range(0, INDEX_MAX)),
                                    1'($urandom_range(0, 1))));
          done++;
        end else if (pick < 92) begin
          // stray load, any index, mark only once the table is whole
          send_request(make_request(CMD_LOAD,
                                    LOAD_INDEX_W'($urandom_range(0, INDEX_MAX)),
                                    tbl_filled && ($urandom_range(0, 1) == 1)));
          done++;
        end else begin
          send_request(make_request(CMD_UNUSED,
                                    LOAD_INDEX_W'($urandom_range(0, INDEX_MAX)),
                                    1'($urandom_range(0, 1))));
        end
      end
    end

    settle();
    if (mismatch_cnt == 0)
      $display("PASS mersenne_twister_generator_top");
    else
      $display("FAIL mersenne_twister_generator_top");
    $finish;
  end

  initial begin : result_check
    int gap;
    logic [WORD_W-1:0] want;
    @(negedge rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      if (expected_words.size() == 0) begin
        $display("%0t: random_word expected none actual %h", $time, m_tdata);
        mismatch_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: random_word expected %h actual %h", $time, want, m_tdata);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAIL mersenne_twister_generator_top");
    $finish;
  end

endmodule
